### rtl/core/pscf_pkg.sv
// Shared types, constants and codes for the priority second-chance FIFO.
`default_nettype none
package pscf_pkg;

  // Table geometry
  localparam int TRACKED_ENTRIES = 256;
  localparam int SCAN_LIMIT      = 8;
  localparam int IDX_W           = $clog2(TRACKED_ENTRIES);
  localparam int CNT_W           = IDX_W + 1;

  // Field widths
  localparam int CMD_W    = 2;
  localparam int CHUNK_W  = 16;
  localparam int OWNER_W  = 32;
  localparam int CHANCE_W = 8;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_ACTIVATE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ACCESS   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_EVICT    = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IGNORED  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOVICTIM = 2'd3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_OWNER   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_OWNER    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_CHANCES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_CHANCES  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_CHANCES  = 3'd4;

  // Memory write operations
  localparam logic [2:0] WR_NONE  = 3'd0;
  localparam logic [2:0] WR_NEW   = 3'd1;
  localparam logic [2:0] WR_DEC   = 3'd2;
  localparam logic [2:0] WR_SHIFT = 3'd3;
  localparam logic [2:0] WR_TAIL  = 3'd4;

  // One FIFO position
  typedef struct packed {
    logic [CHUNK_W-1:0]  chunk;
    logic [CHANCE_W-1:0] chance;
    logic [CHANCE_W-1:0] init_val;
  } pscf_entry_t;

  // Controller to datapath
  typedef struct packed {
    logic       load_item;
    logic       idx_clr;
    logic       idx_inc;
    logic       rd_cur;
    logic       rd_next;
    logic [2:0] wr_op;
    logic       cnt_inc;
    logic       cnt_dec;
    logic       save_hit;
  } pscf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [CMD_W-1:0]   cmd;
    logic               owner_zero;
    logic               hit;
    logic               zero;
    logic               warned;
    logic               in_range;
    logic               scan_ok;
    logic               shift_more;
    logic               full;
    logic [CHUNK_W-1:0] saved_chunk;
  } pscf_stat_t;

endpackage
`default_nettype wire

### rtl/core/pscf_if.sv
// Valid/ready channel interfaces for input items and results.
`default_nettype none
interface pscf_in_if;
  import pscf_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   cmd;
  logic [CHUNK_W-1:0] chunk_id;
  logic [OWNER_W-1:0] owner_id;
  modport source (output valid, cmd, chunk_id, owner_id, input ready);
  modport sink   (input valid, cmd, chunk_id, owner_id, output ready);
endinterface

interface pscf_out_if;
  import pscf_pkg::*;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic                moved_to_tail;
  logic                victim_valid;
  logic [CHUNK_W-1:0]  victim_chunk;
  modport source (output valid, status, moved_to_tail, victim_valid, victim_chunk, input ready);
  modport sink   (input valid, status, moved_to_tail, victim_valid, victim_chunk, output ready);
endinterface
`default_nettype wire

### rtl/core/pscf_dp.sv
// Datapath: config registers, FIFO entry memory, index and count registers.
`default_nettype none
module pscf_dp (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [pscf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pscf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [pscf_pkg::CMD_W-1:0]      in_cmd,
  input  wire logic [pscf_pkg::CHUNK_W-1:0]    in_chunk,
  input  wire logic [pscf_pkg::OWNER_W-1:0]    in_owner,
  input  wire pscf_pkg::pscf_cmd_t             ctl,
  output pscf_pkg::pscf_stat_t                 stat
);
  import pscf_pkg::*;

  logic [OWNER_W-1:0]  high_owner_r, low_owner_r;
  logic [CHANCE_W-1:0] high_ch_r, low_ch_r, def_ch_r;
  logic [CMD_W-1:0]    cmd_r;
  logic [CHUNK_W-1:0]  chunk_r;
  logic [OWNER_W-1:0]  owner_r;
  logic [CNT_W-1:0]    idx_r, idx_nxt, cnt_r, cnt_nxt;
  pscf_entry_t         mem [TRACKED_ENTRIES];
  pscf_entry_t         rdata_r, saved_r, wr_data;
  logic [IDX_W-1:0]    wr_addr, rd_addr;
  logic [CNT_W-1:0]    idx_p1, cnt_m1;
  logic [CHANCE_W-1:0] init_ch;
  logic                wr_en;

  // Configuration writes; unknown indexes do nothing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_owner_r <= '0;
      low_owner_r  <= '0;
      high_ch_r    <= '0;
      low_ch_r     <= '0;
      def_ch_r     <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_HIGH_OWNER:   high_owner_r <= cfg_data;
        CFG_LOW_OWNER:    low_owner_r  <= cfg_data;
        CFG_HIGH_CHANCES: high_ch_r    <= cfg_data[CHANCE_W-1:0];
        CFG_LOW_CHANCES:  low_ch_r     <= cfg_data[CHANCE_W-1:0];
        CFG_DEF_CHANCES:  def_ch_r     <= cfg_data[CHANCE_W-1:0];
        default: ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (ctl.load_item) begin
      cmd_r   <= in_cmd;
      chunk_r <= in_chunk;
      owner_r <= in_owner;
    end
  end

  // Initial chances by owner priority, high match first
  always_comb begin
    if (high_owner_r != '0 && owner_r == high_owner_r) init_ch = high_ch_r;
    else if (low_owner_r != '0 && owner_r == low_owner_r) init_ch = low_ch_r;
    else init_ch = def_ch_r;
  end

  assign idx_p1 = idx_r + CNT_W'(1);
  assign cnt_m1 = cnt_r - CNT_W'(1);

  // Index and live count
  always_comb begin
    idx_nxt = idx_r;
    if (ctl.idx_clr) idx_nxt = '0;
    else if (ctl.idx_inc) idx_nxt = idx_p1;
    cnt_nxt = cnt_r;
    if (ctl.cnt_inc) cnt_nxt = cnt_r + CNT_W'(1);
    else if (ctl.cnt_dec) cnt_nxt = cnt_m1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      cnt_r <= '0;
    end else begin
      idx_r <= idx_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Memory write port select
  always_comb begin
    wr_en   = 1'b1;
    wr_addr = idx_r[IDX_W-1:0];
    wr_data = rdata_r;
    unique case (ctl.wr_op)
      WR_NONE:  wr_en = 1'b0;
      WR_NEW: begin
        wr_addr = cnt_r[IDX_W-1:0];
        wr_data = '{chunk: chunk_r, chance: init_ch, init_val: init_ch};
      end
      WR_DEC:   wr_data.chance = rdata_r.chance - CHANCE_W'(1);
      WR_SHIFT: wr_data = rdata_r;
      WR_TAIL: begin
        wr_addr = cnt_m1[IDX_W-1:0];
        wr_data = saved_r;
      end
      default:  wr_en = 1'b0;
    endcase
  end

  assign rd_addr = ctl.rd_next ? idx_p1[IDX_W-1:0] : idx_r[IDX_W-1:0];

  // Entry memory, registered read
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (ctl.rd_cur || ctl.rd_next) rdata_r <= mem[rd_addr];
  end

  // Capture the hit entry with its chances restored
  always_ff @(posedge clk) begin
    if (ctl.save_hit) saved_r <= '{chunk: rdata_r.chunk, chance: rdata_r.init_val,
                                   init_val: rdata_r.init_val};
  end

  assign stat.cmd         = cmd_r;
  assign stat.owner_zero  = (owner_r == '0);
  assign stat.hit         = (rdata_r.chunk == chunk_r);
  assign stat.zero        = (rdata_r.chance == '0);
  assign stat.warned      = (rdata_r.chance < rdata_r.init_val);
  assign stat.in_range    = (idx_r < cnt_r);
  assign stat.scan_ok     = (idx_r < cnt_r) && (idx_r < CNT_W'(SCAN_LIMIT));
  assign stat.shift_more  = (idx_p1 < cnt_r);
  assign stat.full        = (cnt_r == CNT_W'(TRACKED_ENTRIES));
  assign stat.saved_chunk = saved_r.chunk;

endmodule
`default_nettype wire

### rtl/core/pscf_ctrl.sv
// Controller: sequences lookup, append, move-to-tail and eviction scans.
`default_nettype none
module pscf_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [pscf_pkg::STATUS_W-1:0] out_status,
  output logic                      out_moved,
  output logic                      out_vvalid,
  output logic [pscf_pkg::CHUNK_W-1:0]  out_victim,
  input  wire pscf_pkg::pscf_stat_t stat,
  output pscf_pkg::pscf_cmd_t       ctl
);
  import pscf_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_F_RD  = 4'd2;
  localparam logic [3:0] S_F_EV  = 4'd3;
  localparam logic [3:0] S_SH_RD = 4'd4;
  localparam logic [3:0] S_SH_WR = 4'd5;
  localparam logic [3:0] S_E_RD  = 4'd6;
  localparam logic [3:0] S_E_EV  = 4'd7;
  localparam logic [3:0] S_FIN   = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [STATUS_W-1:0] res_st_r, res_st_nxt;
  logic                res_mv_r, res_mv_nxt, res_vv_r, res_vv_nxt;
  logic                ov_r, ov_nxt;
  logic [STATUS_W-1:0] ost_r, ost_nxt;
  logic                omv_r, omv_nxt, ovv_r, ovv_nxt;
  logic [CHUNK_W-1:0]  ovc_r, ovc_nxt;
  logic                out_free;

  assign out_free = !ov_r || out_ready;
  assign in_ready = (state_r == S_IDLE);

  // Next state and datapath commands
  always_comb begin
    state_nxt  = state_r;
    res_st_nxt = res_st_r;
    res_mv_nxt = res_mv_r;
    res_vv_nxt = res_vv_r;
    ctl        = '0;
    ctl.wr_op  = WR_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.load_item = 1'b1;
          ctl.idx_clr   = 1'b1;
          res_st_nxt    = ST_IGNORED;
          res_mv_nxt    = 1'b0;
          res_vv_nxt    = 1'b0;
          state_nxt     = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.cmd)
          CMD_ACTIVATE: state_nxt = stat.owner_zero ? S_FIN : S_F_RD;
          CMD_ACCESS:   state_nxt = S_F_RD;
          CMD_EVICT:    state_nxt = S_E_RD;
          default:      state_nxt = S_FIN;
        endcase
      end
      // Walk the list looking for the chunk
      S_F_RD: begin
        if (stat.in_range) begin
          ctl.rd_cur = 1'b1;
          state_nxt  = S_F_EV;
        end else begin
          state_nxt = S_FIN;
          if (stat.cmd == CMD_ACTIVATE) begin
            if (stat.full) begin
              res_st_nxt = ST_FULL;
            end else begin
              ctl.wr_op   = WR_NEW;
              ctl.cnt_inc = 1'b1;
              res_st_nxt  = ST_DONE;
            end
          end
        end
      end
      S_F_EV: begin
        if (stat.hit) begin
          state_nxt = S_FIN;
          if (stat.cmd == CMD_ACCESS) begin
            res_st_nxt = ST_DONE;
            if (stat.warned) begin
              ctl.save_hit = 1'b1;
              res_mv_nxt   = 1'b1;
              state_nxt    = S_SH_RD;
            end
          end
        end else begin
          ctl.idx_inc = 1'b1;
          state_nxt   = S_F_RD;
        end
      end
      // Close the gap left by the removed entry
      S_SH_RD: begin
        if (stat.shift_more) begin
          ctl.rd_next = 1'b1;
          state_nxt   = S_SH_WR;
        end else begin
          if (stat.cmd == CMD_ACCESS) ctl.wr_op = WR_TAIL;
          else ctl.cnt_dec = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SH_WR: begin
        ctl.wr_op   = WR_SHIFT;
        ctl.idx_inc = 1'b1;
        state_nxt   = S_SH_RD;
      end
      // Eviction scan from the head
      S_E_RD: begin
        if (stat.scan_ok) begin
          ctl.rd_cur = 1'b1;
          state_nxt  = S_E_EV;
        end else begin
          res_st_nxt = ST_NOVICTIM;
          state_nxt  = S_FIN;
        end
      end
      S_E_EV: begin
        if (stat.zero) begin
          ctl.save_hit = 1'b1;
          res_st_nxt   = ST_DONE;
          res_vv_nxt   = 1'b1;
          state_nxt    = S_SH_RD;
        end else begin
          ctl.wr_op   = WR_DEC;
          ctl.idx_inc = 1'b1;
          state_nxt   = S_E_RD;
        end
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output register: load at finish, drop on take
  always_comb begin
    ov_nxt  = ov_r;
    ost_nxt = ost_r;
    omv_nxt = omv_r;
    ovv_nxt = ovv_r;
    ovc_nxt = ovc_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    if (state_r == S_FIN && out_free) begin
      ov_nxt  = 1'b1;
      ost_nxt = res_st_r;
      omv_nxt = res_mv_r;
      ovv_nxt = res_vv_r;
      ovc_nxt = res_vv_r ? stat.saved_chunk : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_st_r <= res_st_nxt;
    res_mv_r <= res_mv_nxt;
    res_vv_r <= res_vv_nxt;
    ost_r    <= ost_nxt;
    omv_r    <= omv_nxt;
    ovv_r    <= ovv_nxt;
    ovc_r    <= ovc_nxt;
  end

  assign out_valid  = ov_r;
  assign out_status = ost_r;
  assign out_moved  = omv_r;
  assign out_vvalid = ovv_r;
  assign out_victim = ovc_r;

endmodule
`default_nettype wire

### rtl/core/priority_second_chance_fifo.sv
// Top level of the priority second-chance FIFO replacement tracker.
// One command beat is processed at a time and gives exactly one result beat. Activate
// and access walk the list from the head, reading each live entry from memory and then
// comparing it; a rescued access and a successful evict then close the gap by moving
// each following entry up one place, a read and then a write. Evict scans at most
// eight entries. The entry memory has one read and one write port. A finished result
// waits in an output register while the next command beat is taken. No clearing pass
// is needed after reset.
`default_nettype none
module priority_second_chance_fifo (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  pscf_in_if.sink                            in_ch,
  pscf_out_if.source                         out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [pscf_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [pscf_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pscf_pkg::*;

  pscf_cmd_t  ctl;
  pscf_stat_t stat;

  pscf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .out_valid  (out_ch.valid),
    .out_ready  (out_ch.ready),
    .out_status (out_ch.status),
    .out_moved  (out_ch.moved_to_tail),
    .out_vvalid (out_ch.victim_valid),
    .out_victim (out_ch.victim_chunk),
    .stat       (stat),
    .ctl        (ctl)
  );

  pscf_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .in_cmd   (in_ch.cmd),
    .in_chunk (in_ch.chunk_id),
    .in_owner (in_ch.owner_id),
    .ctl      (ctl),
    .stat     (stat)
  );

endmodule
`default_nettype wire

### rtl/core/pscf_checker.sv
// Port-level checker for the tracker, bound to the top level.
`default_nettype none
module pscf_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  out_status,
  input wire logic        out_moved,
  input wire logic        out_vvalid,
  input wire logic [15:0] out_victim
);
  import pscf_pkg::*;

  // Hold a result beat until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped before taken");

  // One command at a time: no new beat right after one is taken
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("command beat taken while busy");

  // Moved and victim flags only with done status, never both
  a_flags: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_moved || out_vvalid) |->
      out_status == ST_DONE && !(out_moved && out_vvalid))
    else $error("result flags inconsistent with status");

  // Victim handle is zero without a victim
  a_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_vvalid |-> out_victim == '0)
    else $error("victim handle set without victim");

endmodule

bind priority_second_chance_fifo pscf_checker u_pscf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_status (out_ch.status),
  .out_moved  (out_ch.moved_to_tail),
  .out_vvalid (out_ch.victim_valid),
  .out_victim (out_ch.victim_chunk)
);
`default_nettype wire
